// File: src/cit_pkg.sv
// Package for the three channel interval timer: per-channel state record,
// event and flag codes, and the counter decrement function. No dependencies.
`timescale 1ns / 1ps
package cit_pkg;

   localparam int NumChannelsDefault = 3;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_GATE  = 2'd2;
   localparam logic [1:0] KIND_CLOCK = 2'd3;

   localparam logic [1:0] PORT_CTRL = 2'd3;

   localparam logic [1:0] RL_LATCH = 2'd0;
   localparam logic [1:0] RL_LSB   = 2'd1;
   localparam logic [1:0] RL_MSB   = 2'd2;
   localparam logic [1:0] RL_BOTH  = 2'd3;

   localparam int FL_CW_NEW   = 0;
   localparam int FL_LOAD_NEW = 1;
   localparam int FL_RUN      = 2;
   localparam int FL_TRIG     = 3;
   localparam int FL_GATE     = 4;
   localparam int FL_CLK      = 5;
   localparam int FL_OUT      = 6;

   typedef struct packed {
      logic [7:0]  cw;
      logic [15:0] load;
      logic [15:0] count;
      logic [15:0] latched;
      logic [1:0]  latch_left;
      logic [1:0]  load_left;
      logic        msb_next;
      logic [7:0]  flags;
   } chan_type;

   // One decrement step, with BCD digit fix-up for digits that became 0xF
   function automatic logic [15:0] step_down(input logic [15:0] c, input logic bcd);
      logic [15:0] v;
      v = c - 16'd1;
      if (bcd && v != 16'd0 && v[3:0] == 4'hF) begin
         v[3:0] = 4'h9;
         if (v[7:4] == 4'hF) begin
            v[7:4] = 4'h9;
            if (v[11:8] == 4'hF) begin
               v[11:8] = 4'h9;
               if (v[15:12] == 4'hF) v[15:12] = 4'h9;
            end
         end
      end
      return v;
   endfunction

   function automatic logic [2:0] mode_of(input logic [7:0] cw);
      logic [2:0] m;
      m = cw[3:1];
      if (m == 3'd6) m = 3'd2;
      if (m == 3'd7) m = 3'd3;
      return m;
   endfunction

endpackage

// File: src/three_channel_interval_timer.sv
// Top level of the three channel interval timer: per-channel state memory,
// event update logic and result register. Depends on cit_pkg.
`timescale 1ns / 1ps
// 8253-style timer with NUM_CHANNELS 16-bit down counters. Each request item
// is one bus write, bus read, gate change or clock change and yields one
// response item with the read byte and the out levels. One item per cycle
// sustained while responses are taken: the channel state sits in a memory
// read at acceptance, updated in the next stage and written back. An entry
// written back at the edge where the next item reads it is taken straight
// from the update logic. The response is registered from the update stage.
// The out levels are kept in flip-flops beside the memory so that all of them
// are reported together. No clearing pass: reset contents come from valid bits.
module three_channel_interval_timer #(
   parameter int NUM_CHANNELS = cit_pkg::NumChannelsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [1:0] req_port,
   input  logic [7:0] req_wdata,
   input  logic       req_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_rdata,
   output logic [2:0] rsp_out_levels,
   output logic [2:0] rsp_out_changed
);

   localparam int ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   cit_pkg::chan_type mem [NUM_CHANNELS];
   cit_pkg::chan_type rd_ff;
   logic [NUM_CHANNELS-1:0] written_ff, written_in;
   logic [2:0] outs_ff, outs_in;

   // stage 1: event held while the entry is read
   logic       s1_valid_ff;
   logic [1:0] s1_kind_ff, s1_port_ff;
   logic [7:0] s1_wdata_ff;
   logic       s1_level_ff;
   logic       s1_present_ff;
   logic [ChW-1:0] s1_ch_ff;

   // response register
   logic       rsp_valid_ff;
   logic [7:0] rsp_rdata_ff;
   logic [2:0] rsp_levels_ff, rsp_changed_ff;

   logic advance;
   logic s1_free;
   logic [1:0] req_sel;
   logic req_present;
   logic [ChW-1:0] req_ch;

   cit_pkg::chan_type cur, nxt;
   logic [7:0] rdata_c;
   logic       wr_en;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_free = !s1_valid_ff || advance;
   assign req_ready = s1_free;

   // decode the channel that the item addresses
   always_comb begin
      req_sel = (req_kind == cit_pkg::KIND_WRITE && req_port == cit_pkg::PORT_CTRL)
                ? req_wdata[7:6] : req_port;
      req_present = (req_sel != 2'd3) && ({30'd0, req_sel} < NUM_CHANNELS);
      req_ch = req_sel[ChW-1:0];
   end

   function automatic cit_pkg::chan_type reset_entry(input logic [1:0] ch);
      cit_pkg::chan_type e;
      e.cw = {ch, 6'h32};
      e.load = 16'hFFFF;
      e.count = 16'hFFFF;
      e.latched = 16'd0;
      e.latch_left = 2'd0;
      e.load_left = 2'd0;
      e.msb_next = 1'b0;
      e.flags = 8'd0;
      return e;
   endfunction

   // read the entry of the accepted item, bypassing an entry written this edge
   always_ff @(posedge clock) begin
      if (req_valid && s1_free && req_present) begin
         if (advance && wr_en && s1_ch_ff == req_ch) rd_ff <= nxt;
         else rd_ff <= mem[req_ch];
      end
   end

   // pick the current entry: stored or reset value
   always_comb begin
      if (written_ff[s1_ch_ff]) cur = rd_ff;
      else cur = reset_entry(2'(s1_ch_ff));
   end

   // apply the event to the entry
   always_comb begin
      logic [2:0]  m;
      logic [1:0]  rl;
      logic        gate, old, run, trig, out, hi;
      logic [15:0] v, c;
      nxt = cur;
      rdata_c = 8'd0;
      wr_en = 1'b0;
      m = cit_pkg::mode_of(cur.cw);
      rl = cur.cw[5:4];
      gate = cur.flags[cit_pkg::FL_GATE];
      hi = 1'b0;
      v = 16'd0;
      c = cur.count;
      old = 1'b0;
      run = cur.flags[cit_pkg::FL_RUN];
      trig = cur.flags[cit_pkg::FL_TRIG];
      out = cur.flags[cit_pkg::FL_OUT];
      case (s1_kind_ff)
         cit_pkg::KIND_WRITE: begin
            if (s1_present_ff) begin
               wr_en = 1'b1;
               if (s1_port_ff == cit_pkg::PORT_CTRL) begin
                  if (s1_wdata_ff[5:4] == cit_pkg::RL_LATCH) begin
                     if (cur.latch_left == 2'd0) begin
                        nxt.latch_left = (rl == cit_pkg::RL_BOTH) ? 2'd2 : 2'd1;
                        nxt.latched = cur.count;
                     end
                  end else begin
                     nxt.cw = s1_wdata_ff;
                     nxt.load_left = (s1_wdata_ff[5:4] == cit_pkg::RL_BOTH) ? 2'd2 : 2'd1;
                     nxt.flags[cit_pkg::FL_LOAD_NEW] = 1'b0;
                     nxt.msb_next = 1'b0;
                     nxt.latch_left = 2'd0;
                     nxt.flags[cit_pkg::FL_RUN] = 1'b0;
                     nxt.flags[cit_pkg::FL_OUT] = (cit_pkg::mode_of(s1_wdata_ff) != 3'd0);
                     nxt.flags[cit_pkg::FL_CW_NEW] = 1'b1;
                  end
               end else begin
                  case (rl)
                     cit_pkg::RL_LSB: begin
                        nxt.load = {8'd0, s1_wdata_ff};
                        nxt.load_left = 2'd0;
                     end
                     cit_pkg::RL_MSB: begin
                        nxt.load = {s1_wdata_ff, 8'd0};
                        nxt.load_left = 2'd0;
                     end
                     cit_pkg::RL_BOTH: begin
                        if (cur.load_left == 2'd1) begin
                           nxt.load = cur.load | {s1_wdata_ff, 8'd0};
                           nxt.load_left = 2'd0;
                        end else begin
                           nxt.load = {8'd0, s1_wdata_ff};
                           nxt.load_left = 2'd1;
                           if (m == 3'd0) begin
                              nxt.flags[cit_pkg::FL_RUN] = 1'b0;
                              nxt.flags[cit_pkg::FL_OUT] = 1'b0;
                           end
                        end
                     end
                     default: ;
                  endcase
                  if (nxt.load_left == 2'd0) begin
                     nxt.flags[cit_pkg::FL_LOAD_NEW] = 1'b1;
                     nxt.flags[cit_pkg::FL_RUN] = gate;
                     case (m)
                        3'd0: begin
                           nxt.flags[cit_pkg::FL_OUT] = 1'b0;
                           nxt.flags[cit_pkg::FL_TRIG] = 1'b1;
                        end
                        3'd2, 3'd3: begin
                           nxt.flags[cit_pkg::FL_OUT] = 1'b1;
                           if (!gate) nxt.count = nxt.load;
                           else if (cur.flags[cit_pkg::FL_CW_NEW])
                              nxt.flags[cit_pkg::FL_TRIG] = 1'b1;
                        end
                        3'd4: begin
                           nxt.flags[cit_pkg::FL_OUT] = 1'b1;
                           nxt.flags[cit_pkg::FL_TRIG] = 1'b1;
                        end
                        default: nxt.flags[cit_pkg::FL_OUT] = 1'b1;
                     endcase
                     nxt.flags[cit_pkg::FL_CW_NEW] = 1'b0;
                  end
               end
            end
         end
         cit_pkg::KIND_READ: begin
            if (!s1_present_ff) rdata_c = 8'hFF;
            else begin
               wr_en = 1'b1;
               if (cur.latch_left != 2'd0) begin
                  v = cur.latched;
                  if (rl == cit_pkg::RL_BOTH) begin
                     hi = cur.latch_left != 2'd2;
                     nxt.latch_left = cur.latch_left - 2'd1;
                  end else begin
                     hi = rl == cit_pkg::RL_MSB;
                     nxt.latch_left = 2'd0;
                  end
               end else begin
                  v = cur.count;
                  if (rl == cit_pkg::RL_BOTH) begin
                     hi = cur.msb_next;
                     nxt.msb_next = !cur.msb_next;
                  end else hi = rl == cit_pkg::RL_MSB;
               end
               rdata_c = hi ? v[15:8] : v[7:0];
            end
         end
         cit_pkg::KIND_GATE: begin
            if (s1_present_ff) begin
               wr_en = 1'b1;
               old = gate;
               nxt.flags[cit_pkg::FL_RUN] = s1_level_ff;
               if (m == 3'd1 || m == 3'd5) begin
                  if (!old && s1_level_ff) nxt.flags[cit_pkg::FL_TRIG] = 1'b1;
               end else if (m == 3'd2 || m == 3'd3) begin
                  if (!s1_level_ff) nxt.flags[cit_pkg::FL_OUT] = 1'b1;
                  else if (!old) nxt.flags[cit_pkg::FL_TRIG] = 1'b1;
               end
               nxt.flags[cit_pkg::FL_GATE] = s1_level_ff;
            end
         end
         default: begin
            if (s1_present_ff) begin
               wr_en = 1'b1;
               nxt.flags[cit_pkg::FL_CLK] = s1_level_ff;
               // falling clock edge: advance the counter
               if (cur.flags[cit_pkg::FL_CLK] && !s1_level_ff) begin
                  case (m)
                     3'd0, 3'd4: begin
                        if (cur.flags[cit_pkg::FL_LOAD_NEW]) begin
                           nxt.count = cur.load;
                           nxt.flags[cit_pkg::FL_LOAD_NEW] = 1'b0;
                        end else if (run) begin
                           c = cit_pkg::step_down(cur.count, cur.cw[0]);
                           nxt.count = c;
                           if (c == 16'd0) nxt.flags[cit_pkg::FL_OUT] = (m == 3'd0);
                           else if (m == 3'd4 && (cur.cw[0] ? c == 16'h9999 : c == 16'hFFFF))
                              nxt.flags[cit_pkg::FL_OUT] = 1'b1;
                        end
                     end
                     3'd1, 3'd5: begin
                        if (trig) begin
                           nxt.flags[cit_pkg::FL_TRIG] = 1'b0;
                           nxt.count = cur.load;
                           nxt.flags[cit_pkg::FL_LOAD_NEW] = 1'b0;
                           nxt.flags[cit_pkg::FL_OUT] = (m != 3'd1);
                           if (m == 3'd1) nxt.flags[cit_pkg::FL_RUN] = 1'b1;
                        end else if (run) begin
                           c = cit_pkg::step_down(cur.count, cur.cw[0]);
                           nxt.count = c;
                           if (c == 16'd0) nxt.flags[cit_pkg::FL_OUT] = (m == 3'd1);
                           else if (m == 3'd5 && (cur.cw[0] ? c == 16'h9999 : c == 16'hFFFF))
                              nxt.flags[cit_pkg::FL_OUT] = 1'b1;
                        end
                     end
                     3'd2: begin
                        if (trig) begin
                           nxt.flags[cit_pkg::FL_TRIG] = 1'b0;
                           nxt.count = cur.load;
                           nxt.flags[cit_pkg::FL_LOAD_NEW] = 1'b0;
                        end else if (run) begin
                           c = cit_pkg::step_down(cur.count, cur.cw[0]);
                           nxt.count = c;
                           if (c == 16'd0) begin
                              nxt.count = cur.load;
                              nxt.flags[cit_pkg::FL_LOAD_NEW] = 1'b0;
                              nxt.flags[cit_pkg::FL_OUT] = 1'b1;
                           end else if (c == 16'd1) nxt.flags[cit_pkg::FL_OUT] = 1'b0;
                        end
                     end
                     default: begin
                        if (trig) begin
                           nxt.count = cur.load;
                           nxt.flags[cit_pkg::FL_LOAD_NEW] = 1'b0;
                           nxt.flags[cit_pkg::FL_TRIG] = 1'b0;
                        end else if (run) begin
                           // half-period steps: up to three decrements
                           if (out) begin
                              c = cit_pkg::step_down(c, cur.cw[0]);
                              if (c[0]) c = cit_pkg::step_down(c, cur.cw[0]);
                           end else begin
                              if (c[0]) c = cit_pkg::step_down(c, cur.cw[0]);
                              c = cit_pkg::step_down(c, cur.cw[0]);
                              c = cit_pkg::step_down(c, cur.cw[0]);
                           end
                           nxt.count = c;
                           if (c == 16'd0) begin
                              nxt.flags[cit_pkg::FL_LOAD_NEW] = 1'b0;
                              if (!((!out && cur.load == 16'd3) || (out && cur.load == 16'd1)))
                                 nxt.count = cur.load;
                              nxt.flags[cit_pkg::FL_OUT] = !out;
                           end
                        end
                     end
                  endcase
               end
            end
         end
      endcase
   end

   // gather the out levels after the event
   always_comb begin
      outs_in = outs_ff;
      written_in = written_ff;
      if (advance && wr_en) begin
         written_in[s1_ch_ff] = 1'b1;
         outs_in[s1_ch_ff] = nxt.flags[cit_pkg::FL_OUT];
      end
   end

   // write back the entry
   always_ff @(posedge clock) begin
      if (advance && wr_en) mem[s1_ch_ff] <= nxt;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         written_ff <= '0;
         outs_ff <= 3'd0;
      end else begin
         if (s1_free) s1_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         written_ff <= written_in;
         outs_ff <= outs_in;
      end
   end

   // item payload and response payload
   always_ff @(posedge clock) begin
      if (req_valid && s1_free) begin
         s1_kind_ff <= req_kind;
         s1_port_ff <= req_port;
         s1_wdata_ff <= req_wdata;
         s1_level_ff <= req_level;
         s1_present_ff <= req_present;
         s1_ch_ff <= req_ch;
      end
      if (advance) begin
         rsp_rdata_ff <= rdata_c;
         rsp_levels_ff <= outs_in;
         rsp_changed_ff <= outs_in ^ outs_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rsp_rdata_ff;
   assign rsp_out_levels = rsp_levels_ff;
   assign rsp_out_changed = rsp_changed_ff;

   // a response waiting without being taken holds the pipeline stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && s1_valid_ff |=> s1_valid_ff)
      else $error("stage dropped an item under stall");
   // levels reported match the stored levels
   a_levels: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_out_levels == outs_ff)
      else $error("reported levels differ from stored levels");
   // a read never changes any out level
   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      advance && s1_kind_ff == cit_pkg::KIND_READ |=> rsp_out_changed == 3'd0)
      else $error("read changed an out level");

endmodule

// File: tb/tb_top.sv
// Self-checking bench for three_channel_interval_timer: drives timer events,
// predicts read bytes and out levels with its own timer model. Depends on cit_pkg.
`timescale 1ns / 1ps
module tb_top;

   localparam int NCH = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] port;
      logic [7:0] wdata;
      logic       level;
   } event_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic [2:0] levels;
      logic [2:0] changed;
   } pin_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_kind = '0;
   logic [1:0] req_port = '0;
   logic [7:0] req_wdata = '0;
   logic       req_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_rdata;
   logic [2:0] rsp_out_levels;
   logic [2:0] rsp_out_changed;

   three_channel_interval_timer i_dut (.*);

   // timer model state
   logic [7:0]  m_cw [NCH];
   logic [15:0] m_load [NCH];
   logic [15:0] m_count [NCH];
   logic [15:0] m_latched [NCH];
   logic [1:0]  m_latch_left [NCH];
   logic [1:0]  m_load_left [NCH];
   logic        m_msb_next [NCH];
   logic [7:0]  m_flags [NCH];

   event_type      pending_events[$];
   pin_result_type expected_pins[$];
   int          mismatches = 0;
   int          checked = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_sender = 0;
   int          hold_off_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [2:0] eff_mode(int ch);
      logic [2:0] m;
      m = m_cw[ch][3:1];
      if (m == 3'd6) m = 3'd2;
      if (m == 3'd7) m = 3'd3;
      return m;
   endfunction

   // decrement one count; returns true on reaching zero
   function automatic bit count_down(int ch);
      logic [15:0] v;
      v = m_count[ch] - 16'd1;
      m_count[ch] = v;
      if (v == 16'd0) return 1;
      if (!m_cw[ch][0]) return 0;
      if (v[3:0] == 4'hF) begin
         v[3:0] = 4'h9;
         if (v[7:4] == 4'hF) begin
            v[7:4] = 4'h9;
            if (v[11:8] == 4'hF) begin
               v[11:8] = 4'h9;
               if (v[15:12] == 4'hF) v[15:12] = 4'h9;
            end
         end
         m_count[ch] = v;
      end
      return 0;
   endfunction

   function automatic bit at_wrap(int ch);
      return m_cw[ch][0] ? (m_count[ch] == 16'h9999) : (m_count[ch] == 16'hFFFF);
   endfunction

   function automatic void reload_count(int ch);
      m_count[ch] = m_load[ch];
      m_flags[ch][cit_pkg::FL_LOAD_NEW] = 1'b0;
   endfunction

   function automatic void model_reset();
      for (int ch = 0; ch < NCH; ch++) begin
         m_cw[ch] = 8'((ch << 6) | 8'h32);
         m_load[ch] = 16'hFFFF;
         m_count[ch] = 16'hFFFF;
         m_latched[ch] = '0;
         m_latch_left[ch] = '0;
         m_load_left[ch] = '0;
         m_msb_next[ch] = 1'b0;
         m_flags[ch] = '0;
      end
   endfunction

   function automatic void load_byte(int ch, logic [7:0] b);
      logic [1:0] rl;
      logic       gate;
      rl = m_cw[ch][5:4];
      gate = m_flags[ch][cit_pkg::FL_GATE];
      if (rl == cit_pkg::RL_LSB) begin
         m_load[ch] = {8'h00, b};
         m_load_left[ch] = 2'd0;
      end else if (rl == cit_pkg::RL_MSB) begin
         m_load[ch] = {b, 8'h00};
         m_load_left[ch] = 2'd0;
      end else if (rl == cit_pkg::RL_BOTH) begin
         if (m_load_left[ch] == 2'd1) begin
            m_load[ch] = m_load[ch] | {b, 8'h00};
            m_load_left[ch] = 2'd0;
         end else begin
            m_load[ch] = {8'h00, b};
            m_load_left[ch] = 2'd1;
            if (eff_mode(ch) == 3'd0) begin
               m_flags[ch][cit_pkg::FL_RUN] = 1'b0;
               m_flags[ch][cit_pkg::FL_OUT] = 1'b0;
            end
         end
      end
      if (m_load_left[ch] != 2'd0) return;
      m_flags[ch][cit_pkg::FL_LOAD_NEW] = 1'b1;
      case (eff_mode(ch))
         3'd0: begin
            m_flags[ch][cit_pkg::FL_OUT] = 1'b0;
            m_flags[ch][cit_pkg::FL_RUN] = gate;
            m_flags[ch][cit_pkg::FL_TRIG] = 1'b1;
         end
         3'd2, 3'd3: begin
            m_flags[ch][cit_pkg::FL_OUT] = 1'b1;
            m_flags[ch][cit_pkg::FL_RUN] = gate;
            if (!gate) m_count[ch] = m_load[ch];
            else if (m_flags[ch][cit_pkg::FL_CW_NEW]) m_flags[ch][cit_pkg::FL_TRIG] = 1'b1;
         end
         3'd4: begin
            m_flags[ch][cit_pkg::FL_OUT] = 1'b1;
            m_flags[ch][cit_pkg::FL_RUN] = gate;
            m_flags[ch][cit_pkg::FL_TRIG] = 1'b1;
         end
         default: begin
            m_flags[ch][cit_pkg::FL_OUT] = 1'b1;
            m_flags[ch][cit_pkg::FL_RUN] = gate;
         end
      endcase
      m_flags[ch][cit_pkg::FL_CW_NEW] = 1'b0;
   endfunction

   function automatic void control_byte(logic [7:0] b);
      int ch;
      ch = b[7:6];
      if (ch == 3 || ch >= NCH) return;
      if (b[5:4] == cit_pkg::RL_LATCH) begin
         if (m_latch_left[ch] == 2'd0) begin
            m_latch_left[ch] = (m_cw[ch][5:4] == cit_pkg::RL_BOTH) ? 2'd2 : 2'd1;
            m_latched[ch] = m_count[ch];
         end
         return;
      end
      m_cw[ch] = b;
      m_load_left[ch] = (b[5:4] == cit_pkg::RL_BOTH) ? 2'd2 : 2'd1;
      m_flags[ch][cit_pkg::FL_LOAD_NEW] = 1'b0;
      m_msb_next[ch] = 1'b0;
      m_latch_left[ch] = 2'd0;
      m_flags[ch][cit_pkg::FL_RUN] = 1'b0;
      m_flags[ch][cit_pkg::FL_OUT] = (eff_mode(ch) != 3'd0);
      m_flags[ch][cit_pkg::FL_CW_NEW] = 1'b1;
   endfunction

   function automatic logic [7:0] read_byte(int ch);
      logic [1:0]  rl;
      logic [15:0] v;
      bit          hi;
      rl = m_cw[ch][5:4];
      if (m_latch_left[ch] > 2'd0) begin
         v = m_latched[ch];
         if (rl == cit_pkg::RL_BOTH) begin
            hi = (m_latch_left[ch] != 2'd2);
            m_latch_left[ch] = m_latch_left[ch] - 2'd1;
         end else begin
            hi = (rl == cit_pkg::RL_MSB);
            m_latch_left[ch] = 2'd0;
         end
      end else begin
         v = m_count[ch];
         if (rl == cit_pkg::RL_BOTH) begin
            hi = m_msb_next[ch];
            m_msb_next[ch] = ~m_msb_next[ch];
         end else begin
            hi = (rl == cit_pkg::RL_MSB);
         end
      end
      return hi ? v[15:8] : v[7:0];
   endfunction

   function automatic void gate_change(int ch, logic lv);
      logic       old;
      logic [2:0] m;
      old = m_flags[ch][cit_pkg::FL_GATE];
      m = eff_mode(ch);
      m_flags[ch][cit_pkg::FL_RUN] = lv;
      if (m == 3'd1 || m == 3'd5) begin
         if (!old && lv) m_flags[ch][cit_pkg::FL_TRIG] = 1'b1;
      end else if (m == 3'd2 || m == 3'd3) begin
         if (!lv) m_flags[ch][cit_pkg::FL_OUT] = 1'b1;
         else if (!old) m_flags[ch][cit_pkg::FL_TRIG] = 1'b1;
      end
      m_flags[ch][cit_pkg::FL_GATE] = lv;
   endfunction

   function automatic void falling_clock(int ch);
      logic [2:0] m;
      logic       run, trig, out;
      bit         z;
      m = eff_mode(ch);
      run = m_flags[ch][cit_pkg::FL_RUN];
      trig = m_flags[ch][cit_pkg::FL_TRIG];
      out = m_flags[ch][cit_pkg::FL_OUT];
      case (m)
         3'd0, 3'd4: begin
            if (m_flags[ch][cit_pkg::FL_LOAD_NEW]) reload_count(ch);
            else if (run) begin
               if (count_down(ch)) m_flags[ch][cit_pkg::FL_OUT] = (m == 3'd0);
               else if (m == 3'd4 && at_wrap(ch)) m_flags[ch][cit_pkg::FL_OUT] = 1'b1;
            end
         end
         3'd1, 3'd5: begin
            if (trig) begin
               m_flags[ch][cit_pkg::FL_TRIG] = 1'b0;
               reload_count(ch);
               if (m == 3'd1) begin
                  m_flags[ch][cit_pkg::FL_OUT] = 1'b0;
                  m_flags[ch][cit_pkg::FL_RUN] = 1'b1;
               end else m_flags[ch][cit_pkg::FL_OUT] = 1'b1;
            end else if (run) begin
               if (count_down(ch)) m_flags[ch][cit_pkg::FL_OUT] = (m == 3'd1);
               else if (m == 3'd5 && at_wrap(ch)) m_flags[ch][cit_pkg::FL_OUT] = 1'b1;
            end
         end
         3'd2: begin
            if (trig) begin
               m_flags[ch][cit_pkg::FL_TRIG] = 1'b0;
               reload_count(ch);
            end else if (run) begin
               if (count_down(ch)) begin
                  reload_count(ch);
                  m_flags[ch][cit_pkg::FL_OUT] = 1'b1;
               end else if (m_count[ch] == 16'd1) m_flags[ch][cit_pkg::FL_OUT] = 1'b0;
            end
         end
         default: begin
            if (trig) begin
               reload_count(ch);
               m_flags[ch][cit_pkg::FL_TRIG] = 1'b0;
            end else if (run) begin
               if (out) begin
                  z = count_down(ch);
                  if (m_count[ch][0]) z = count_down(ch);
               end else begin
                  if (m_count[ch][0]) z = count_down(ch);
                  z = count_down(ch);
                  z = count_down(ch);
               end
               if (m_count[ch] == 16'd0) begin
                  m_flags[ch][cit_pkg::FL_LOAD_NEW] = 1'b0;
                  // odd mode 3 loads of 3 and 1 skip the reload on one half
                  if (!((!out && m_load[ch] == 16'd3) || (out && m_load[ch] == 16'd1)))
                     m_count[ch] = m_load[ch];
                  m_flags[ch][cit_pkg::FL_OUT] = !out;
               end
            end
         end
      endcase
   endfunction

   function automatic logic [2:0] pin_levels();
      logic [2:0] r;
      r = '0;
      for (int ch = 0; ch < NCH; ch++) r[ch] = m_flags[ch][cit_pkg::FL_OUT];
      return r;
   endfunction

   function automatic pin_result_type predict_event(event_type e);
      pin_result_type r;
      logic [2:0]  prior;
      int          ch;
      prior = pin_levels();
      ch = e.port;
      r.rdata = '0;
      case (e.kind)
         cit_pkg::KIND_WRITE: if (e.port == cit_pkg::PORT_CTRL) control_byte(e.wdata);
            else load_byte(ch, e.wdata);
         cit_pkg::KIND_READ: r.rdata = (e.port == cit_pkg::PORT_CTRL) ? 8'hFF : read_byte(ch);
         cit_pkg::KIND_GATE: if (e.port != cit_pkg::PORT_CTRL) gate_change(ch, e.level);
         default: if (e.port != cit_pkg::PORT_CTRL) begin
            logic old;
            old = m_flags[ch][cit_pkg::FL_CLK];
            m_flags[ch][cit_pkg::FL_CLK] = e.level;
            if (old && !e.level) falling_clock(ch);
         end
      endcase
      r.levels = pin_levels();
      r.changed = prior ^ r.levels;
      return r;
   endfunction

   function automatic void push_event(logic [1:0] k, logic [1:0] p, logic [7:0] d,
                                      logic lv);
      event_type e;
      e.kind = k;
      e.port = p;
      e.wdata = d;
      e.level = lv;
      pending_events.push_back(e);
   endfunction

   // program a counter: control word then load bytes to match its rl field
   function automatic void push_program(int ch, logic [1:0] rl, logic [2:0] m,
                                        logic bcd, logic [15:0] v);
      push_event(cit_pkg::KIND_WRITE, cit_pkg::PORT_CTRL, {2'(ch), rl, m, bcd}, 1'b0);
      if (rl == cit_pkg::RL_MSB) push_event(cit_pkg::KIND_WRITE, 2'(ch), v[15:8], 1'b0);
      else push_event(cit_pkg::KIND_WRITE, 2'(ch), v[7:0], 1'b0);
      if (rl == cit_pkg::RL_BOTH) push_event(cit_pkg::KIND_WRITE, 2'(ch), v[15:8], 1'b0);
   endfunction

   function automatic void push_random_burst();
      int         ch;
      logic [15:0] v;
      ch = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
         0: push_event(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
         1: begin
            v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
            push_program(ch, 2'($urandom_range(1, 3)), 3'($urandom), 1'($urandom), v);
         end
         2: push_event(cit_pkg::KIND_WRITE, cit_pkg::PORT_CTRL,
                       {2'(ch), cit_pkg::RL_LATCH, 4'($urandom)}, 1'b0);
         3: push_event(cit_pkg::KIND_READ, 2'($urandom_range(0, 3)), 8'($urandom),
                       1'($urandom));
         4: push_event(cit_pkg::KIND_GATE, 2'($urandom_range(0, 3)), 8'($urandom),
                       1'($urandom));
         default: begin
            // clock pulse train on one channel
            repeat ($urandom_range(1, 3)) begin
               push_event(cit_pkg::KIND_CLOCK, 2'(ch), 8'($urandom), 1'b1);
               push_event(cit_pkg::KIND_CLOCK, 2'(ch), 8'($urandom), 1'b0);
            end
         end
      endcase
   endfunction

   // driver: present the oldest pending item, advance on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_pins.push_back(predict_event(
               event_type'{req_kind, req_port, req_wdata, req_level}));
            void'(pending_events.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_events.size() > 0 && !hold_sender
                && $urandom_range(0, 99) >= send_idle_pct) begin
               event_type e;
               e = pending_events[0];
               req_valid <= 1'b1;
               req_kind <= e.kind;
               req_port <= e.port;
               req_wdata <= e.wdata;
               req_level <= e.level;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pins.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
            end else begin
               pin_result_type x;
               x = expected_pins.pop_front();
               checked++;
               if (x.rdata !== rsp_rdata || x.levels !== rsp_out_levels
                   || x.changed !== rsp_out_changed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp rdata %h out %b chg %b, got %h %b %b",
                              x.rdata, x.levels, x.changed, rsp_rdata, rsp_out_levels,
                              rsp_out_changed);
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic drain_all();
      while (pending_events.size() != 0 || req_valid || expected_pins.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      int rounds;
      int n0;
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reads after reset, modes 0 and 3, BCD wrap, latches, odd mode 3 loads
      push_event(cit_pkg::KIND_READ, 2'd0, 8'h00, 1'b0);
      push_event(cit_pkg::KIND_READ, cit_pkg::PORT_CTRL, 8'hFF, 1'b1);
      push_event(cit_pkg::KIND_WRITE, cit_pkg::PORT_CTRL, 8'hF6, 1'b0);
      push_event(cit_pkg::KIND_GATE, cit_pkg::PORT_CTRL, 8'h00, 1'b1);
      push_event(cit_pkg::KIND_GATE, 2'd0, 8'h00, 1'b1);
      push_event(cit_pkg::KIND_GATE, 2'd1, 8'h00, 1'b1);
      push_event(cit_pkg::KIND_GATE, 2'd2, 8'h00, 1'b1);
      push_program(0, cit_pkg::RL_BOTH, 3'd3, 1'b0, 16'd3);
      push_program(1, cit_pkg::RL_LSB, 3'd3, 1'b0, 16'd1);
      push_program(2, cit_pkg::RL_MSB, 3'd0, 1'b1, 16'h0000);
      for (int ch = 0; ch < 3; ch++)
         repeat (3) begin
            push_event(cit_pkg::KIND_CLOCK, 2'(ch), 8'h00, 1'b1);
            push_event(cit_pkg::KIND_CLOCK, 2'(ch), 8'h00, 1'b0);
         end
      push_event(cit_pkg::KIND_WRITE, cit_pkg::PORT_CTRL, 8'h00, 1'b0);
      push_event(cit_pkg::KIND_WRITE, cit_pkg::PORT_CTRL, 8'h00, 1'b0);
      push_event(cit_pkg::KIND_READ, 2'd0, 8'h00, 1'b0);
      push_event(cit_pkg::KIND_READ, 2'd0, 8'h00, 1'b0);
      drain_all();

      // random phases with different idle patterns
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 74 : (ph == 3) ? 8 : 0;
         recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 8 : 0;
         rounds = 0;
         while (rounds < 410) begin
            n0 = pending_events.size();
            push_random_burst();
            rounds = rounds + pending_events.size() - n0;
            while (pending_events.size() > 40) @(posedge clock);
         end
         if (ph == 0) begin
            // long receiver hold-off while the sender keeps offering items
            hold_off_cycles <= 200;
            repeat (60) push_random_burst();
         end
         while (pending_events.size() != 0 || req_valid) @(posedge clock);
         // sender pause until every result has come
         hold_sender = 1;
         while (expected_pins.size() != 0) @(posedge clock);
         hold_sender = 0;
      end
      drain_all();

      $display("Checked %0d result items over write, read, gate and clock events", checked);
      $display("in four idling phases, with %0d mismatches", mismatches);
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: three_channel_interval_timer.f
src/cit_pkg.sv
src/three_channel_interval_timer.sv
tb/tb_top.sv
